// ===== rtl/core/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants for the priority schedule table: job record,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 5;
  localparam int TIME_W  = 20;
  localparam int AVG_W   = 28;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [AVG_W-1:0]  AVG_MAX  = '1;

  localparam logic ROW_JOB = 1'b0;
  localparam logic ROW_SUM = 1'b1;

  localparam logic DIV_WAIT = 1'b0;
  localparam logic DIV_TURN = 1'b1;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [ID_W-1:0]    id;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GO,
    S_LD_I,
    S_CMP,
    S_WR_I,
    S_ERD,
    S_EROW,
    S_DIV_W,
    S_WAIT_W,
    S_DIV_T,
    S_WAIT_T,
    S_SUM
  } state_t;

  // read address source for the table
  typedef enum logic [1:0] {
    RA_I,
    RA_I1,
    RA_J1,
    RA_K
  } rsel_t;

  typedef struct packed {
    logic  load;
    logic  run_clear;
    logic  cur_load;
    logic  cmp_step;
    logic  wr_i;
    rsel_t raddr_sel;
    logic  emit_row;
    logic  div_start;
    logic  div_sel;
    logic  emit_sum;
  } cmd_t;

  typedef struct packed {
    logic n_ge2;
    logic j_last;
    logic i_last;
    logic k_last;
    logic out_free;
    logic div_busy;
  } sts_t;

endpackage

// ===== rtl/core/pst_ram.sv =====
// ----------------------------------------------------------------------------
// pst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pst_ctrl.sv =====
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer for load, exchange sort, row emission, averaging and summary.
// ----------------------------------------------------------------------------
module pst_ctrl
  import pst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last_job,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.raddr_sel = RA_I;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.run_clear = 1'b1;
        cmd.load      = in_valid;
        if (in_valid && in_last_job) begin
          state_nxt = S_GO;
        end
      end
      S_GO: begin
        // read of entry zero is issued here
        cmd.raddr_sel = RA_I;
        state_nxt = sts.n_ge2 ? S_LD_I : S_ERD;
      end
      S_LD_I: begin
        cmd.cur_load  = 1'b1;
        cmd.raddr_sel = RA_I1;
        state_nxt     = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_step  = 1'b1;
        cmd.raddr_sel = RA_J1;
        if (sts.j_last) begin
          state_nxt = S_WR_I;
        end
      end
      S_WR_I: begin
        cmd.wr_i      = 1'b1;
        cmd.raddr_sel = RA_I1;
        state_nxt     = sts.i_last ? S_ERD : S_LD_I;
      end
      S_ERD: begin
        cmd.raddr_sel = RA_K;
        state_nxt     = S_EROW;
      end
      S_EROW: begin
        cmd.raddr_sel = RA_K;
        if (sts.out_free) begin
          cmd.emit_row = 1'b1;
          state_nxt    = sts.k_last ? S_DIV_W : S_ERD;
        end
      end
      S_DIV_W: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_WAIT;
        state_nxt     = S_WAIT_W;
      end
      S_WAIT_W: begin
        if (!sts.div_busy) begin
          state_nxt = S_DIV_T;
        end
      end
      S_DIV_T: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_TURN;
        state_nxt     = S_WAIT_T;
      end
      S_WAIT_T: begin
        if (!sts.div_busy) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.emit_sum = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/pst_dp.sv =====
// ----------------------------------------------------------------------------
// pst_dp
// Datapath: job table, sort registers, running times, serial divider and
// the output register.
// ----------------------------------------------------------------------------
module pst_dp
  import pst_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [BURST_W-1:0] in_burst_time,
  input  logic [PRIO_W-1:0]  in_job_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_row_kind,
  output logic [ID_W-1:0]    out_job_id,
  output logic [BURST_W-1:0] out_job_burst,
  output logic [PRIO_W-1:0]  out_job_prio,
  output logic [TIME_W-1:0]  out_wait_time,
  output logic [TIME_W-1:0]  out_turn_time,
  output logic [AVG_W-1:0]   out_avg_wait_q8,
  output logic [AVG_W-1:0]   out_avg_turn_q8,
  output logic               out_overflow,
  output logic               out_end_of_run
);

  localparam int CW  = $clog2(MAX_PROCS + 1);
  localparam int AW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int TW  = BURST_W + CW;
  localparam int SW  = TW + CW;
  localparam int DW  = SW + 8;
  localparam int DCW = $clog2(DW);
  localparam int XW  = (TW > TIME_W) ? TW : TIME_W;
  localparam int QW  = (DW > AVG_W) ? DW : AVG_W;

  logic [CW-1:0] count_r;
  logic          drop_r;
  logic [AW-1:0] i_r, j_r, k_r;
  job_t          cur_r;
  logic [TW-1:0] clock_r;
  logic [SW-1:0] sum_w_r, sum_t_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  job_t          ram_wdata;
  logic [JOB_W-1:0] ram_rdata;
  job_t          rd_job;

  logic          full;
  logic          swap;
  logic [TW-1:0] turn_full;
  logic [XW-1:0] wait_ext, turn_ext;

  // divider
  logic            div_busy_r;
  logic            div_sel_r;
  logic [DCW-1:0]  div_cnt_r;
  logic [DW-1:0]   div_num_r;
  logic [DW-1:0]   div_quo_r;
  logic [CW-1:0]   div_rem_r;
  logic [CW:0]     rem_sh, rem_nxt;
  logic            q_bit;
  logic [DW-1:0]   q_fin;
  logic [QW-1:0]   q_ext;
  logic [AVG_W-1:0] q_sat;
  logic [AVG_W-1:0] avg_w_r, avg_t_r;

  assign rd_job = job_t'(ram_rdata);
  assign full   = (count_r == CW'(MAX_PROCS));
  assign swap   = (cur_r.prio > rd_job.prio);

  // table write port: load, swap at j, or put back the minimum at i
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_r;
    ram_wdata = cur_r;
    if (cmd.load) begin
      ram_we          = !full;
      ram_waddr       = count_r[AW-1:0];
      ram_wdata.burst = in_burst_time;
      ram_wdata.prio  = in_job_priority;
      ram_wdata.id    = ID_W'(count_r + CW'(1));
    end else if (cmd.cmp_step) begin
      ram_we    = swap;
      ram_waddr = j_r;
    end else if (cmd.wr_i) begin
      ram_we    = 1'b1;
      ram_waddr = i_r;
    end
  end

  always_comb begin
    case (cmd.raddr_sel)
      RA_I:    ram_raddr = i_r;
      RA_I1:   ram_raddr = i_r + AW'(1);
      RA_J1:   ram_raddr = j_r + AW'(1);
      RA_K:    ram_raddr = k_r;
      default: ram_raddr = i_r;
    endcase
  end

  pst_ram #(
    .WIDTH (JOB_W),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign turn_full = clock_r + TW'(rd_job.burst);
  assign wait_ext  = XW'(clock_r);
  assign turn_ext  = XW'(turn_full);

  // count, drop flag and sort/emit indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        drop_r <= 1'b1;
      end else begin
        count_r <= count_r + CW'(1);
      end
    end else if (cmd.emit_sum) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_clear) begin
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      clock_r <= '0;
      sum_w_r <= '0;
      sum_t_r <= '0;
    end else begin
      if (cmd.cur_load) begin
        cur_r <= rd_job;
        j_r   <= i_r + AW'(1);
      end
      if (cmd.cmp_step) begin
        if (swap) begin
          cur_r <= rd_job;
        end
        j_r <= j_r + AW'(1);
      end
      if (cmd.wr_i) begin
        i_r <= i_r + AW'(1);
      end
      if (cmd.emit_row) begin
        k_r     <= k_r + AW'(1);
        clock_r <= turn_full;
        sum_w_r <= sum_w_r + SW'(clock_r);
        sum_t_r <= sum_t_r + SW'(turn_full);
      end
    end
  end

  // restoring divider, one quotient bit per cycle, shared by both averages
  assign rem_sh  = {div_rem_r, div_num_r[DW-1]};
  assign q_bit   = (rem_sh >= {1'b0, count_r});
  assign rem_nxt = q_bit ? (rem_sh - {1'b0, count_r}) : rem_sh;
  assign q_fin   = {div_quo_r[DW-2:0], q_bit};
  assign q_ext   = QW'(q_fin);

  always_comb begin
    if (count_r == '0) begin
      q_sat = '0;
    end else if (q_ext > QW'(AVG_MAX)) begin
      q_sat = AVG_MAX;
    end else begin
      q_sat = q_ext[AVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && (div_cnt_r == DCW'(DW - 1))) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel;
      div_cnt_r <= '0;
      div_rem_r <= '0;
      div_quo_r <= '0;
      div_num_r <= (cmd.div_sel == DIV_TURN) ? {sum_t_r, 8'b0} : {sum_w_r, 8'b0};
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + DCW'(1);
      div_rem_r <= rem_nxt[CW-1:0];
      div_quo_r <= q_fin;
      div_num_r <= {div_num_r[DW-2:0], 1'b0};
      if (div_cnt_r == DCW'(DW - 1)) begin
        if (div_sel_r == DIV_TURN) begin
          avg_t_r <= q_sat;
        end else begin
          avg_w_r <= q_sat;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_row || cmd.emit_sum) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_row) begin
      out_row_kind    <= ROW_JOB;
      out_job_id      <= rd_job.id;
      out_job_burst   <= rd_job.burst;
      out_job_prio    <= rd_job.prio;
      out_wait_time   <= (wait_ext > XW'(TIME_MAX)) ? TIME_MAX : wait_ext[TIME_W-1:0];
      out_turn_time   <= (turn_ext > XW'(TIME_MAX)) ? TIME_MAX : turn_ext[TIME_W-1:0];
      out_avg_wait_q8 <= '0;
      out_avg_turn_q8 <= '0;
      out_overflow    <= 1'b0;
      out_end_of_run  <= 1'b0;
    end else if (cmd.emit_sum) begin
      out_row_kind    <= ROW_SUM;
      out_job_id      <= '0;
      out_job_burst   <= '0;
      out_job_prio    <= '0;
      out_wait_time   <= '0;
      out_turn_time   <= '0;
      out_avg_wait_q8 <= avg_w_r;
      out_avg_turn_q8 <= avg_t_r;
      out_overflow    <= drop_r;
      out_end_of_run  <= 1'b1;
    end
  end

  always_comb begin
    sts.n_ge2    = (count_r > CW'(1));
    sts.j_last   = ((CW'(j_r) + CW'(1)) == count_r);
    sts.i_last   = ((CW'(i_r) + CW'(2)) >= count_r);
    sts.k_last   = ((CW'(k_r) + CW'(1)) == count_r);
    sts.out_free = !out_valid || !out_stall;
    sts.div_busy = div_busy_r;
  end

endmodule

// ===== rtl/core/priority_schedule_table_top.sv =====
// Sequence: each load writes one job; after the last item the block sorts the
// table in place, emits one row per job (an emit waits while the output is
// stalled), and runs two serial divisions, one for each average time.
// Throughput: one item per cycle while loading; no input is taken from the
// last item until the summary row is in the output register (sort in place).
// Reset: synchronous, active low; clears job count, drop flag, state, valid.
// ----------------------------------------------------------------------------
// priority_schedule_table_top
// Non-preemptive priority schedule: loads jobs, sorts by priority and emits
// one row per job followed by a summary with Q8 average times.
// ----------------------------------------------------------------------------
module priority_schedule_table_top
  import pst_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BURST_W-1:0] in_burst_time,
  input  logic [PRIO_W-1:0]  in_job_priority,
  input  logic               in_last_job,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_row_kind,
  output logic [ID_W-1:0]    out_job_id,
  output logic [BURST_W-1:0] out_job_burst,
  output logic [PRIO_W-1:0]  out_job_prio,
  output logic [TIME_W-1:0]  out_wait_time,
  output logic [TIME_W-1:0]  out_turn_time,
  output logic [AVG_W-1:0]   out_avg_wait_q8,
  output logic [AVG_W-1:0]   out_avg_turn_q8,
  output logic               out_overflow,
  output logic               out_end_of_run
);

  cmd_t cmd;
  sts_t sts;

  pst_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_job (in_last_job),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (in_stall)
  );

  pst_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_burst_time   (in_burst_time),
    .in_job_priority (in_job_priority),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_kind    (out_row_kind),
    .out_job_id      (out_job_id),
    .out_job_burst   (out_job_burst),
    .out_job_prio    (out_job_prio),
    .out_wait_time   (out_wait_time),
    .out_turn_time   (out_turn_time),
    .out_avg_wait_q8 (out_avg_wait_q8),
    .out_avg_turn_q8 (out_avg_turn_q8),
    .out_overflow    (out_overflow),
    .out_end_of_run  (out_end_of_run)
  );

`ifndef SYNTH
  // last beat hands control to the scheduler
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_job |=> in_stall)
    else $error("input not stalled after last job");

  a_sum_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_kind == ROW_SUM) |-> out_end_of_run && (out_job_id == '0))
    else $error("summary row malformed");

  a_turn_ge_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_kind == ROW_JOB) |-> (out_turn_time >= out_wait_time)
      && !out_end_of_run)
    else $error("job row times inconsistent");
`endif

endmodule
